// ===== sv/rtc_fmt_pkg.sv =====
// shared types, constants and digit helpers for the rtc time format codec
`timescale 1ns / 1ps

package rtc_fmt_pkg;

  // operation carried with each item
  typedef enum logic [0:0] {
    FUNC_ENCODE = 1'b0,
    FUNC_DECODE = 1'b1
  } func_t;

  // register index on the configuration port
  typedef enum logic [0:0] {
    REG_BINARY_MODE = 1'b0,
    REG_HOUR_24     = 1'b1
  } reg_idx_t;

  // mode bits from status register b
  typedef struct packed {
    logic binary;
    logic h24;
  } mode_t;

  // calendar fields of one item
  typedef struct packed {
    logic [11:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
  } time_t;

  localparam int unsigned TDATA_W = 56;

  localparam logic [7:0]  MAX_SEC_MIN = 8'd59;
  localparam logic [7:0]  MAX_HOUR_24 = 8'd23;
  localparam logic [7:0]  NOON_HOUR   = 8'd12;
  localparam logic [7:0]  MAX_DAY     = 8'd31;
  localparam logic [7:0]  MAX_MONTH   = 8'd12;
  localparam logic [7:0]  MAX_YY      = 8'd99;
  localparam logic [7:0]  ONE_CENTURY = 8'd100;
  localparam logic [7:0]  TWO_CENTURY = 8'd200;
  localparam logic [11:0] YEAR_BASE   = 12'd1970;
  localparam logic [11:0] YEAR_LAST   = 12'd2069;
  localparam logic [11:0] CENTURY_LO  = 12'd1900;
  localparam logic [11:0] CENTURY_HI  = 12'd2000;
  localparam logic [6:0]  YY_PIVOT    = 7'd70;

  // year / 100 as multiply by reciprocal, exact for 12-bit years
  localparam logic [12:0] YR_RECIP = 13'd5243;
  localparam int unsigned YR_SHIFT = 19;

  // v / 10 for an 8-bit value
  function automatic logic [4:0] div10(input logic [7:0] v);
    logic [15:0] p;
    p = 16'(v) * 16'd205;
    return p[15:11];
  endfunction

  // bcd byte from value and its tenths quotient, kept to 8 bits
  function automatic logic [7:0] to_bcd(input logic [7:0] v, input logic [4:0] q);
    logic [7:0] lo;
    lo = v - ({3'b000, q} << 3) - ({3'b000, q} << 1);
    return {q[3:0], lo[3:0]};
  endfunction

  // register byte to value, bcd digits unchecked
  function automatic logic [7:0] dec_val(input logic [7:0] b, input logic binary);
    logic [7:0] tens;
    tens = {4'b0000, b[7:4]} * 8'd10;
    return binary ? b : (tens + {4'b0000, b[3:0]});
  endfunction

  // non-decimal digit in either nibble
  function automatic logic nib_bad(input logic [7:0] b);
    return (b[7:4] > 4'd9) || (b[3:0] > 4'd9);
  endfunction

endpackage

// ===== sv/rtc_fmt_pipe.sv =====
// three-stage conversion pipeline for encode and decode of rtc time bytes
`timescale 1ns / 1ps

module rtc_fmt_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  rtc_fmt_pkg::mode_t  mode,
  input  logic                in_valid,
  output logic                in_ready,
  input  rtc_fmt_pkg::func_t  in_func,
  input  rtc_fmt_pkg::time_t  in_time,
  output logic                out_valid,
  input  logic                out_ready,
  output rtc_fmt_pkg::time_t  out_time,
  output logic                out_bad
);
  import rtc_fmt_pkg::*;

  typedef struct packed {
    func_t       func;
    logic [7:0]  sec;
    logic [7:0]  min;
    logic [7:0]  hr;
    logic [7:0]  day;
    logic [7:0]  mon;
    logic        pm;
    logic [11:0] yr;
    logic [5:0]  yq;
    logic        bad;
  } s1_t;

  typedef struct packed {
    func_t       func;
    logic [7:0]  sec;
    logic [7:0]  min;
    logic [7:0]  hr;
    logic [7:0]  day;
    logic [7:0]  mon;
    logic [4:0]  qsec;
    logic [4:0]  qmin;
    logic [4:0]  qhr;
    logic [4:0]  qday;
    logic [4:0]  qmon;
    logic        pm;
    logic [6:0]  yr;
    logic        bad;
  } s2_t;

  logic        v1_r, v2_r, v3_r;
  logic        rdy1, rdy2, rdy3;
  s1_t         s1_nxt, s1_r;
  s2_t         s2_nxt, s2_r;
  time_t       out_time_nxt, out_time_r;
  logic        out_bad_nxt, out_bad_r;

  logic [24:0] yprod;
  logic [7:0]  enc_h;
  logic        enc_pm;
  logic [7:0]  hr_byte;
  logic [11:0] ymul;
  logic [11:0] ydiff;
  logic [7:0]  dh;
  logic [7:0]  yy;
  logic [4:0]  yq10;

  // stall chain: a stage moves when it is empty or the next one moves
  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // stage 1: range checks, 12-hour fold, digit decode, year quotient
  always_comb begin
    yprod   = 25'(in_time.year) * 25'(YR_RECIP);
    hr_byte = mode.h24 ? in_time.hour : {1'b0, in_time.hour[6:0]};
    enc_h   = in_time.hour;
    enc_pm  = 1'b0;
    if (!mode.h24) begin
      if (enc_h >= NOON_HOUR) begin
        enc_h  = enc_h - NOON_HOUR;
        enc_pm = 1'b1;
      end
      if (enc_h == 8'd0) begin
        enc_h = NOON_HOUR;
      end
    end
    s1_nxt      = '0;
    s1_nxt.func = in_func;
    s1_nxt.yq   = yprod[YR_SHIFT +: 6];
    unique case (in_func)
      FUNC_ENCODE: begin
        s1_nxt.sec = in_time.second;
        s1_nxt.min = in_time.minute;
        s1_nxt.hr  = enc_h;
        s1_nxt.pm  = enc_pm;
        s1_nxt.day = in_time.day;
        s1_nxt.mon = in_time.month;
        s1_nxt.yr  = in_time.year;
        s1_nxt.bad = (in_time.second > MAX_SEC_MIN) || (in_time.minute > MAX_SEC_MIN) ||
                     (in_time.hour > MAX_HOUR_24) || (in_time.day == 8'd0) ||
                     (in_time.day > MAX_DAY) || (in_time.month == 8'd0) ||
                     (in_time.month > MAX_MONTH) || (in_time.year < YEAR_BASE) ||
                     (in_time.year > YEAR_LAST);
      end
      FUNC_DECODE: begin
        s1_nxt.sec = dec_val(in_time.second, mode.binary);
        s1_nxt.min = dec_val(in_time.minute, mode.binary);
        s1_nxt.hr  = dec_val(hr_byte, mode.binary);
        s1_nxt.pm  = in_time.hour[7];
        s1_nxt.day = dec_val(in_time.day, mode.binary);
        s1_nxt.mon = dec_val(in_time.month, mode.binary);
        s1_nxt.yr  = {4'b0000, dec_val(in_time.year[7:0], mode.binary)};
        s1_nxt.bad = (in_time.year[11:8] != 4'd0) ||
                     (!mode.binary && (nib_bad(in_time.second) || nib_bad(in_time.minute) ||
                                       nib_bad(hr_byte) || nib_bad(in_time.day) ||
                                       nib_bad(in_time.month) ||
                                       nib_bad(in_time.year[7:0])));
      end
      default: s1_nxt.bad = 1'b0;
    endcase
  end

  // stage 2: tenths quotients, year modulo 100, decoded range and hour map
  always_comb begin
    ymul  = {6'b000000, s1_r.yq} * 12'd100;
    ydiff = s1_r.yr - ymul;
    dh    = s1_r.hr;
    yy    = s1_r.yr[7:0];
    s2_nxt      = '0;
    s2_nxt.func = s1_r.func;
    s2_nxt.sec  = s1_r.sec;
    s2_nxt.min  = s1_r.min;
    s2_nxt.day  = s1_r.day;
    s2_nxt.mon  = s1_r.mon;
    s2_nxt.pm   = s1_r.pm;
    s2_nxt.qsec = div10(s1_r.sec);
    s2_nxt.qmin = div10(s1_r.min);
    s2_nxt.qhr  = div10(s1_r.hr);
    s2_nxt.qday = div10(s1_r.day);
    s2_nxt.qmon = div10(s1_r.mon);
    s2_nxt.hr   = s1_r.hr;
    s2_nxt.bad  = s1_r.bad;
    unique case (s1_r.func)
      FUNC_ENCODE: begin
        s2_nxt.yr = ydiff[6:0];
      end
      FUNC_DECODE: begin
        // hour: 24-hour passes, 12-hour maps twelve to zero then adds pm
        if (mode.h24) begin
          if (dh > MAX_HOUR_24) s2_nxt.bad = 1'b1;
        end else begin
          if ((dh == 8'd0) || (dh > NOON_HOUR)) s2_nxt.bad = 1'b1;
          if (dh == NOON_HOUR) dh = 8'd0;
          if (s1_r.pm) dh = dh + NOON_HOUR;
        end
        s2_nxt.hr = dh;
        if ((s1_r.sec > MAX_SEC_MIN) || (s1_r.min > MAX_SEC_MIN) || (s1_r.day == 8'd0) ||
            (s1_r.day > MAX_DAY) || (s1_r.mon == 8'd0) || (s1_r.mon > MAX_MONTH) ||
            (yy > MAX_YY)) begin
          s2_nxt.bad = 1'b1;
        end
        // two-digit year folded back below one hundred
        if (yy >= TWO_CENTURY) begin
          yy = yy - TWO_CENTURY;
        end else if (yy >= ONE_CENTURY) begin
          yy = yy - ONE_CENTURY;
        end
        s2_nxt.yr = yy[6:0];
      end
      default: s2_nxt.yr = 7'd0;
    endcase
  end

  // stage 3: bcd packing or binary pass-through for encode, year windowing for decode
  always_comb begin
    yq10         = div10({1'b0, s2_r.yr});
    out_time_nxt = '0;
    out_bad_nxt  = s2_r.bad;
    unique case (s2_r.func)
      FUNC_ENCODE: begin
        if (mode.binary) begin
          out_time_nxt.second = s2_r.sec;
          out_time_nxt.minute = s2_r.min;
          out_time_nxt.hour   = s2_r.hr | {s2_r.pm, 7'b0000000};
          out_time_nxt.day    = s2_r.day;
          out_time_nxt.month  = s2_r.mon;
          out_time_nxt.year   = {5'b00000, s2_r.yr};
        end else begin
          out_time_nxt.second = to_bcd(s2_r.sec, s2_r.qsec);
          out_time_nxt.minute = to_bcd(s2_r.min, s2_r.qmin);
          out_time_nxt.hour   = to_bcd(s2_r.hr, s2_r.qhr) | {s2_r.pm, 7'b0000000};
          out_time_nxt.day    = to_bcd(s2_r.day, s2_r.qday);
          out_time_nxt.month  = to_bcd(s2_r.mon, s2_r.qmon);
          out_time_nxt.year   = {4'b0000, to_bcd({1'b0, s2_r.yr}, yq10)};
        end
      end
      FUNC_DECODE: begin
        out_time_nxt.second = s2_r.sec;
        out_time_nxt.minute = s2_r.min;
        out_time_nxt.hour   = s2_r.hr;
        out_time_nxt.day    = s2_r.day;
        out_time_nxt.month  = s2_r.mon;
        out_time_nxt.year   = (s2_r.yr < YY_PIVOT) ? (CENTURY_HI + 12'(s2_r.yr))
                                                   : (CENTURY_LO + 12'(s2_r.yr));
      end
      default: out_bad_nxt = s2_r.bad;
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // payload stages, loaded only with a live item
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) s1_r <= s1_nxt;
    if (rdy2 && v1_r) s2_r <= s2_nxt;
    if (rdy3 && v2_r) begin
      out_time_r <= out_time_nxt;
      out_bad_r  <= out_bad_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_time  = out_time_r;
  assign out_bad   = out_bad_r;

endmodule

// ===== sv/cmos_rtc_time_format_codec.sv =====
// top level of the rtc time format codec: stream ports, mode registers, pipeline
//
//   channel | direction | handshake               | contents
//   in_     | slave     | in_tvalid / in_tready   | tdata: time fields, tuser: func
//   out_    | master    | out_tvalid / out_tready | tdata: time fields, tuser: bad_input
//   cfg     | apb slave | psel, penable, pready   | binary_mode at 0x0, hour_24_mode at 0x4
//
// one item per clock while out_tready is high; each item passes through the three register
// stages (digit prep, quotients and range, bcd pack and year window).
// rst_n is synchronous; it empties the pipeline and clears both mode bits to zero.
// a stall on out_tready holds each full stage whose later stages are all full; empty stages still fill.
`timescale 1ns / 1ps

module cmos_rtc_time_format_codec (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // second [7:0], minute [15:8], hour [23:16], day [31:24], month [39:32],
  // year [51:40], zero [55:52]
  input  logic [rtc_fmt_pkg::TDATA_W-1:0]    in_tdata,
  // func [0]
  input  logic [0:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_second [7:0], out_minute [15:8], out_hour [23:16], out_day [31:24],
  // out_month [39:32], out_year [51:40], zero [55:52]
  output logic [rtc_fmt_pkg::TDATA_W-1:0]    out_tdata,
  // bad_input [0]
  output logic [0:0]                         out_tuser,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import rtc_fmt_pkg::*;

  logic     binary_mode_r;
  logic     hour_24_mode_r;
  logic     cfg_wr;
  reg_idx_t cfg_idx;
  mode_t    mode;
  time_t    in_time;
  time_t    out_time;
  logic     out_bad;

  // configuration port, word index from address bit 2
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      binary_mode_r  <= 1'b0;
      hour_24_mode_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_BINARY_MODE: binary_mode_r  <= pwdata[0];
        REG_HOUR_24:     hour_24_mode_r <= pwdata[0];
        default:         binary_mode_r  <= binary_mode_r;
      endcase
    end
  end

  // register read back
  always_comb begin
    prdata = 32'd0;
    unique case (cfg_idx)
      REG_BINARY_MODE: prdata[0] = binary_mode_r;
      REG_HOUR_24:     prdata[0] = hour_24_mode_r;
      default:         prdata    = 32'd0;
    endcase
  end

  assign mode.binary = binary_mode_r;
  assign mode.h24    = hour_24_mode_r;

  // unpack the input item
  assign in_time.second = in_tdata[7:0];
  assign in_time.minute = in_tdata[15:8];
  assign in_time.hour   = in_tdata[23:16];
  assign in_time.day    = in_tdata[31:24];
  assign in_time.month  = in_tdata[39:32];
  assign in_time.year   = in_tdata[51:40];

  rtc_fmt_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_func   (func_t'(in_tuser[0])),
    .in_time   (in_time),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_time  (out_time),
    .out_bad   (out_bad)
  );

  // pack the result item
  assign out_tdata = {4'b0000, out_time.year, out_time.month, out_time.day,
                      out_time.hour, out_time.minute, out_time.second};
  assign out_tuser = out_bad;

endmodule
